// ===== rtl/scl_pkg.sv =====
// Shared types, codes and byte classifiers of the shell command lexer.
`default_nettype none
package scl_pkg;

  localparam int NSLOT = 5;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_QUOTE = 2'd2;
  localparam logic [1:0] MODE_ESC   = 2'd3;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LT   = 3'd1;
  localparam logic [2:0] OP_GT   = 3'd2;
  localparam logic [2:0] OP_BAR  = 3'd3;
  localparam logic [2:0] OP_AMP  = 3'd4;

  localparam logic [3:0] TK_WORD      = 4'd0;
  localparam logic [3:0] TK_REDIR_IN  = 4'd1;
  localparam logic [3:0] TK_HEREDOC   = 4'd2;
  localparam logic [3:0] TK_REDIR_OUT = 4'd3;
  localparam logic [3:0] TK_APPEND    = 4'd4;
  localparam logic [3:0] TK_PIPE      = 4'd5;
  localparam logic [3:0] TK_OR        = 4'd6;
  localparam logic [3:0] TK_AND       = 4'd7;
  localparam logic [3:0] TK_SEMI      = 4'd8;
  localparam logic [3:0] TK_ILLEGAL   = 4'd9;
  localparam logic [3:0] TK_EOF       = 4'd10;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] tk;
  } slot_t;

  // All result beats that one input byte causes, in order.
  typedef struct packed {
    logic [2:0]            count;
    slot_t [NSLOT-1:0]     slot;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] r;
    r = OP_NONE;
    if (c == CH_LT) r = OP_LT;
    else if (c == CH_GT) r = OP_GT;
    else if (c == CH_BAR) r = OP_BAR;
    else if (c == CH_AMP) r = OP_AMP;
    return r;
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] op);
    logic [7:0] r;
    unique case (op)
      OP_LT:   r = CH_LT;
      OP_GT:   r = CH_GT;
      OP_BAR:  r = CH_BAR;
      OP_AMP:  r = CH_AMP;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] op_single(input logic [2:0] op);
    logic [3:0] r;
    unique case (op)
      OP_LT:   r = TK_REDIR_IN;
      OP_GT:   r = TK_REDIR_OUT;
      OP_BAR:  r = TK_PIPE;
      default: r = TK_WORD;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] op_double(input logic [2:0] op);
    logic [3:0] r;
    unique case (op)
      OP_LT:   r = TK_HEREDOC;
      OP_GT:   r = TK_APPEND;
      OP_BAR:  r = TK_OR;
      OP_AMP:  r = TK_AND;
      default: r = TK_WORD;
    endcase
    return r;
  endfunction

  function automatic bundle_t push(input bundle_t b, input logic k,
                                   input logic [7:0] d, input logic [3:0] tk);
    bundle_t r;
    r = b;
    r.slot[r.count].kind = k;
    r.slot[r.count].data = d;
    r.slot[r.count].tk   = tk;
    r.count = r.count + 3'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/shell_command_lexer_unit.sv =====
// Top level of the shell command lexer: front end, bundle queue, output sequencer.
// The result beats of a byte pass through the bundle queue and the output register.
// Throughput: one input byte per cycle while the queue has room; the output side
// sends one result beat per cycle while tok_stall is low.
// Bytes that produce nothing (skipped whitespace, a held operator) add no queue entry.
// Reset clears the lexer mode, the held operator, the queue and the output valid flag.
`default_nettype none
module shell_command_lexer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        ch_valid,
  output logic       ch_stall,
  input  wire  [7:0] ch,
  output logic       tok_valid,
  input  wire        tok_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [3:0] token_kind,
  output logic       last
);

  scl_pkg::q_status_t q_status;
  scl_pkg::bundle_t   push_data;
  scl_pkg::bundle_t   pop_data;
  logic               push_en;
  logic               pop_en;

  scl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch        (ch),
    .ch_stall  (ch_stall),
    .q_status  (q_status),
    .push_en   (push_en),
    .push_data (push_data)
  );

  scl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push_data (push_data),
    .pop_en    (pop_en),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  scl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop_en     (pop_en),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .token_kind (token_kind),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== rtl/scl_front.sv =====
// Front end: accepts bytes, tracks the lexer mode and builds result bundles.
`default_nettype none
module scl_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  ch_valid,
  input  wire  [7:0]           ch,
  output logic                 ch_stall,
  input  scl_pkg::q_status_t   q_status,
  output logic                 push_en,
  output scl_pkg::bundle_t     push_data
);

  logic [1:0] lex_mode, lex_mode_next;
  logic       quote_is_double, quote_is_double_next;
  logic       quote_has_content, quote_has_content_next;
  logic [2:0] held_operator, held_operator_next;
  logic       accept;

  assign ch_stall = q_status.full;
  assign accept   = ch_valid && !ch_stall;

  always_comb begin
    scl_pkg::bundle_t b;
    logic             do_idle;
    logic [7:0]       closer;
    logic [2:0]       op;
    b = '0;
    do_idle = 1'b0;
    closer = quote_is_double ? scl_pkg::CH_DQUOTE : scl_pkg::CH_SQUOTE;
    op = scl_pkg::op_code(ch);
    lex_mode_next = lex_mode;
    quote_is_double_next = quote_is_double;
    quote_has_content_next = quote_has_content;
    held_operator_next = held_operator;

    unique case (lex_mode)
      scl_pkg::MODE_QUOTE, scl_pkg::MODE_ESC: begin
        if (ch == scl_pkg::CH_NUL) begin
          b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_ILLEGAL);
          b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_EOF);
          lex_mode_next = scl_pkg::MODE_IDLE;
        end else if (lex_mode == scl_pkg::MODE_ESC) begin
          b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
          lex_mode_next = scl_pkg::MODE_QUOTE;
        end else if (ch == closer) begin
          if (quote_has_content) begin
            b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_WORD);
          end else begin
            b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
            b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_ILLEGAL);
          end
          lex_mode_next = scl_pkg::MODE_IDLE;
        end else begin
          b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
          quote_has_content_next = 1'b1;
          if (ch == scl_pkg::CH_BSLASH) lex_mode_next = scl_pkg::MODE_ESC;
        end
      end
      scl_pkg::MODE_WORD: begin
        if (ch == scl_pkg::CH_NUL || scl_pkg::is_space(ch) || ch == scl_pkg::CH_SEMI ||
            op != scl_pkg::OP_NONE) begin
          b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_WORD);
          lex_mode_next = scl_pkg::MODE_IDLE;
          do_idle = !scl_pkg::is_space(ch);
        end else begin
          b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
        end
      end
      default: begin
        held_operator_next = scl_pkg::OP_NONE;
        if (held_operator != scl_pkg::OP_NONE && ch == scl_pkg::op_char(held_operator)) begin
          b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
          b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
          b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0,
                            scl_pkg::op_double(held_operator));
          lex_mode_next = scl_pkg::MODE_IDLE;
        end else begin
          // A cut-off operator goes out in its one-byte form; a lone '&' is dropped.
          if (held_operator != scl_pkg::OP_NONE && held_operator != scl_pkg::OP_AMP) begin
            b = scl_pkg::push(b, scl_pkg::KIND_BYTE, scl_pkg::op_char(held_operator),
                              scl_pkg::TK_WORD);
            b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0,
                              scl_pkg::op_single(held_operator));
          end
          do_idle = 1'b1;
        end
      end
    endcase

    if (do_idle) begin
      lex_mode_next = scl_pkg::MODE_IDLE;
      if (ch == scl_pkg::CH_NUL) begin
        b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_EOF);
      end else if (scl_pkg::is_space(ch)) begin
        b = b;
      end else if (ch == scl_pkg::CH_SEMI) begin
        b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
        b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_SEMI);
      end else if (op != scl_pkg::OP_NONE) begin
        held_operator_next = op;
      end else if (ch == scl_pkg::CH_SQUOTE || ch == scl_pkg::CH_DQUOTE) begin
        lex_mode_next = scl_pkg::MODE_QUOTE;
        quote_is_double_next = (ch == scl_pkg::CH_DQUOTE);
        quote_has_content_next = 1'b0;
      end else if (scl_pkg::is_word_start(ch)) begin
        b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
        lex_mode_next = scl_pkg::MODE_WORD;
      end else begin
        b = scl_pkg::push(b, scl_pkg::KIND_BYTE, ch, scl_pkg::TK_WORD);
        b = scl_pkg::push(b, scl_pkg::KIND_END, 8'd0, scl_pkg::TK_ILLEGAL);
      end
    end

    push_data = b;
  end

  // Skipped whitespace produces nothing, so no bundle enters the queue.
  assign push_en = accept && (push_data.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= scl_pkg::MODE_IDLE;
      quote_is_double <= 1'b0;
      quote_has_content <= 1'b0;
      held_operator <= scl_pkg::OP_NONE;
    end else if (accept) begin
      lex_mode <= lex_mode_next;
      quote_is_double <= quote_is_double_next;
      quote_has_content <= quote_has_content_next;
      held_operator <= held_operator_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scl_queue.sv =====
// Short bundle queue between the front end and the output sequencer.
`default_nettype none
module scl_queue #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_en,
  input  scl_pkg::bundle_t     push_data,
  input  wire                  pop_en,
  output scl_pkg::bundle_t     pop_data,
  output scl_pkg::q_status_t   q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scl_pkg::bundle_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_status.full     = (fill == FULL_CNT);
  assign q_status.nonempty = (fill != '0);
  assign pop_data          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push_en) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop_en) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push_en && !pop_en) fill <= fill + 1'b1;
      else if (pop_en && !push_en) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scl_back.sv =====
// Output sequencer: plays each bundle out one result beat per cycle while tok_stall is low.
`default_nettype none
module scl_back (
  input  wire                  clk,
  input  wire                  rst,
  input  scl_pkg::q_status_t   q_status,
  input  scl_pkg::bundle_t     pop_data,
  output logic                 pop_en,
  output logic                 tok_valid,
  input  wire                  tok_stall,
  output logic                 kind,
  output logic [7:0]           out_byte,
  output logic [3:0]           token_kind,
  output logic                 last
);

  scl_pkg::bundle_t cur;
  logic             cur_valid;
  logic [2:0]       idx;
  logic             final_beat;
  logic             finish;
  scl_pkg::slot_t   s;

  assign final_beat = (idx == cur.count - 3'd1);
  assign finish     = cur_valid && !tok_stall && final_beat;
  assign pop_en     = q_status.nonempty && (!cur_valid || finish);

  assign s          = cur.slot[idx];
  assign tok_valid  = cur_valid;
  assign kind       = s.kind;
  assign out_byte   = s.data;
  assign token_kind = s.tk;
  assign last       = final_beat;

  always_ff @(posedge clk) begin
    if (pop_en) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (pop_en) begin
      cur_valid <= 1'b1;
      idx <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && !tok_stall) begin
      idx <= idx + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scl_checker.sv =====
// Port-level checks of the shell command lexer, bound to the top level.
`default_nettype none
module scl_checker (
  input wire       clk,
  input wire       rst,
  input wire       ch_valid,
  input wire       ch_stall,
  input wire [7:0] ch,
  input wire       tok_valid,
  input wire       tok_stall,
  input wire       kind,
  input wire [7:0] out_byte,
  input wire [3:0] token_kind,
  input wire       last
);

  // A stalled input beat stays offered with the same byte.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_stall |=> ch_valid && $stable(ch))
    else $error("input beat changed while stalled");

  // A stalled result beat stays in place with the same contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(kind) && $stable(out_byte) &&
      $stable(token_kind) && $stable(last))
    else $error("result beat changed while stalled");

  // End-of-token beats carry no content byte.
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    tok_valid && kind == scl_pkg::KIND_END |-> out_byte == 8'd0)
    else $error("end beat with a content byte");

  // Content beats carry no token type.
  a_byte_kind: assert property (@(posedge clk) disable iff (rst)
    tok_valid && kind == scl_pkg::KIND_BYTE |-> token_kind == scl_pkg::TK_WORD)
    else $error("content beat with a token type");

  // The end-of-line marker is always the final beat of its byte.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && kind == scl_pkg::KIND_END && token_kind == scl_pkg::TK_EOF |-> last)
    else $error("eof beat not marked last");

endmodule

bind shell_command_lexer_unit scl_checker u_scl_checker (
  .clk        (clk),
  .rst        (rst),
  .ch_valid   (ch_valid),
  .ch_stall   (ch_stall),
  .ch         (ch),
  .tok_valid  (tok_valid),
  .tok_stall  (tok_stall),
  .kind       (kind),
  .out_byte   (out_byte),
  .token_kind (token_kind),
  .last       (last)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the shell command lexer: random lines, random stalls.
`timescale 1ns / 100ps
module testbench;

  localparam int QUIET_TAIL = 40;
  localparam int RANDOM_TARGET = 345;
  localparam int N_OPENING = 28;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] tk;
    logic       last;
  } token_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       ch_valid = 1'b0;
  logic       ch_stall;
  logic [7:0] ch = 8'h00;
  logic       tok_valid;
  logic       tok_stall = 1'b0;
  logic       kind;
  logic [7:0] out_byte;
  logic [3:0] token_kind;
  logic       last;

  logic [7:0]  pending_bytes[$];
  token_beat_t beats_due[$];
  logic [7:0]  opening_line [0:N_OPENING-1];

  // Lexer state as the predictor sees it.
  logic [1:0] scan_mode = scl_pkg::MODE_IDLE;
  logic       in_dquote = 1'b0;
  logic       quote_nonempty = 1'b0;
  logic [2:0] held_op = scl_pkg::OP_NONE;

  int mismatches = 0;
  int bytes_taken = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  bit pressure_done = 1'b0;

  shell_command_lexer_unit uut (
    .clk(clk),
    .rst(rst),
    .ch_valid(ch_valid),
    .ch_stall(ch_stall),
    .ch(ch),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .kind(kind),
    .out_byte(out_byte),
    .token_kind(token_kind),
    .last(last)
  );

  always #10 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == scl_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [2:0] op_of(input logic [7:0] c);
    case (c)
      scl_pkg::CH_LT:  return scl_pkg::OP_LT;
      scl_pkg::CH_GT:  return scl_pkg::OP_GT;
      scl_pkg::CH_BAR: return scl_pkg::OP_BAR;
      scl_pkg::CH_AMP: return scl_pkg::OP_AMP;
      default:         return scl_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic starts_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == scl_pkg::CH_UNDER);
  endfunction

  function automatic logic [7:0] op_text(input logic [2:0] op);
    case (op)
      scl_pkg::OP_LT:  return scl_pkg::CH_LT;
      scl_pkg::OP_GT:  return scl_pkg::CH_GT;
      scl_pkg::OP_BAR: return scl_pkg::CH_BAR;
      default:         return scl_pkg::CH_AMP;
    endcase
  endfunction

  function automatic logic [3:0] op_token(input logic [2:0] op, input logic doubled);
    case (op)
      scl_pkg::OP_LT:  return doubled ? scl_pkg::TK_HEREDOC : scl_pkg::TK_REDIR_IN;
      scl_pkg::OP_GT:  return doubled ? scl_pkg::TK_APPEND : scl_pkg::TK_REDIR_OUT;
      scl_pkg::OP_BAR: return doubled ? scl_pkg::TK_OR : scl_pkg::TK_PIPE;
      default:         return scl_pkg::TK_AND;
    endcase
  endfunction

  function automatic void add_beat(input logic k, input logic [7:0] d, input logic [3:0] tk);
    token_beat_t b;
    b.kind = k;
    b.data = d;
    b.tk = tk;
    b.last = 1'b0;
    beats_due.push_back(b);
  endfunction

  // A byte seen with no token open and no operator pending.
  function automatic void lex_fresh(input logic [7:0] c);
    logic [2:0] op;
    op = op_of(c);
    scan_mode = scl_pkg::MODE_IDLE;
    if (c == scl_pkg::CH_NUL) begin
      add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_EOF);
    end else if (is_blank(c)) begin
    end else if (c == scl_pkg::CH_SEMI) begin
      add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
      add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_SEMI);
    end else if (op != scl_pkg::OP_NONE) begin
      held_op = op;
    end else if (c == scl_pkg::CH_SQUOTE || c == scl_pkg::CH_DQUOTE) begin
      scan_mode = scl_pkg::MODE_QUOTE;
      in_dquote = (c == scl_pkg::CH_DQUOTE);
      quote_nonempty = 1'b0;
    end else if (starts_word(c)) begin
      add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
      scan_mode = scl_pkg::MODE_WORD;
    end else begin
      add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
      add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_ILLEGAL);
    end
  endfunction

  // Works out every beat one accepted byte causes and queues them.
  function automatic void lex_byte(input logic [7:0] c);
    logic [2:0]  h;
    logic [7:0]  closer;
    int          n0;
    token_beat_t b;
    n0 = beats_due.size();
    if (scan_mode == scl_pkg::MODE_QUOTE || scan_mode == scl_pkg::MODE_ESC) begin
      closer = in_dquote ? scl_pkg::CH_DQUOTE : scl_pkg::CH_SQUOTE;
      if (c == scl_pkg::CH_NUL) begin
        add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_ILLEGAL);
        add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_EOF);
        scan_mode = scl_pkg::MODE_IDLE;
      end else if (scan_mode == scl_pkg::MODE_ESC) begin
        add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
        scan_mode = scl_pkg::MODE_QUOTE;
      end else if (c == closer) begin
        if (quote_nonempty) begin
          add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_WORD);
        end else begin
          add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
          add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_ILLEGAL);
        end
        scan_mode = scl_pkg::MODE_IDLE;
      end else begin
        add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
        quote_nonempty = 1'b1;
        if (c == scl_pkg::CH_BSLASH) scan_mode = scl_pkg::MODE_ESC;
      end
    end else if (scan_mode == scl_pkg::MODE_WORD) begin
      if (c == scl_pkg::CH_NUL || is_blank(c) || c == scl_pkg::CH_SEMI ||
          op_of(c) != scl_pkg::OP_NONE) begin
        add_beat(scl_pkg::KIND_END, 8'h00, scl_pkg::TK_WORD);
        scan_mode = scl_pkg::MODE_IDLE;
        if (!is_blank(c)) lex_fresh(c);
      end else begin
        add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
      end
    end else begin
      h = held_op;
      held_op = scl_pkg::OP_NONE;
      if (h != scl_pkg::OP_NONE && c == op_text(h)) begin
        add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
        add_beat(scl_pkg::KIND_BYTE, c, scl_pkg::TK_WORD);
        add_beat(scl_pkg::KIND_END, 8'h00, op_token(h, 1'b1));
        scan_mode = scl_pkg::MODE_IDLE;
      end else begin
        // A lone ampersand vanishes; other cut-off operators go out single.
        if (h != scl_pkg::OP_NONE && h != scl_pkg::OP_AMP) begin
          add_beat(scl_pkg::KIND_BYTE, op_text(h), scl_pkg::TK_WORD);
          add_beat(scl_pkg::KIND_END, 8'h00, op_token(h, 1'b0));
        end
        lex_fresh(c);
      end
    end
    if (beats_due.size() > n0) begin
      b = beats_due.pop_back();
      b.last = 1'b1;
      beats_due.push_back(b);
    end
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'h61 + r[7:0];
    if (r < 52) return 8'h41 + r[7:0] - 8'd26;
    if (r < 62) return 8'h30 + r[7:0] - 8'd52;
    return scl_pkg::CH_UNDER;
  endfunction

  task automatic queue_random_line();
    int         n_tok;
    int         len;
    int         r;
    logic [7:0] q;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      // Pure noise, line end included anywhere.
      repeat ($urandom_range(1, 8)) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
        r = $urandom_range(0, 9);
        if (r <= 2) begin
          pending_bytes.push_back(word_char());
          len = $urandom_range(0, 5);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) pending_bytes.push_back(8'($urandom_range(1, 255)));
            else pending_bytes.push_back(word_char());
          end
        end else if (r <= 4) begin
          q = $urandom_range(0, 1) ? scl_pkg::CH_DQUOTE : scl_pkg::CH_SQUOTE;
          pending_bytes.push_back(q);
          len = $urandom_range(0, 5);
          repeat (len) begin
            c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(32, 126));
            if (c == q || $urandom_range(0, 9) == 0) pending_bytes.push_back(scl_pkg::CH_BSLASH);
            pending_bytes.push_back(c);
          end
          if ($urandom_range(0, 11) != 0) pending_bytes.push_back(q);
        end else if (r <= 6) begin
          case ($urandom_range(0, 8))
            0: pending_bytes.push_back(scl_pkg::CH_LT);
            1: begin
              pending_bytes.push_back(scl_pkg::CH_LT);
              pending_bytes.push_back(scl_pkg::CH_LT);
            end
            2: pending_bytes.push_back(scl_pkg::CH_GT);
            3: begin
              pending_bytes.push_back(scl_pkg::CH_GT);
              pending_bytes.push_back(scl_pkg::CH_GT);
            end
            4: pending_bytes.push_back(scl_pkg::CH_BAR);
            5: begin
              pending_bytes.push_back(scl_pkg::CH_BAR);
              pending_bytes.push_back(scl_pkg::CH_BAR);
            end
            6: begin
              pending_bytes.push_back(scl_pkg::CH_AMP);
              pending_bytes.push_back(scl_pkg::CH_AMP);
            end
            7: pending_bytes.push_back(scl_pkg::CH_SEMI);
            default: pending_bytes.push_back(scl_pkg::CH_AMP);
          endcase
        end else if (r == 7) begin
          pending_bytes.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 6);
            pending_bytes.push_back(r < 5 ? 8'd9 + r[7:0] : scl_pkg::CH_SPACE);
          end
        end
      end
    end
    pending_bytes.push_back(scl_pkg::CH_NUL);
  endtask

  // Sender: offers bytes from the pending queue with random gaps.
  always @(posedge clk) begin : drive_bytes
    logic next_valid;
    next_valid = ch_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (ch_valid && !ch_stall) begin
        lex_byte(ch);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!(ch_valid && ch_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          next_valid = 1'b0;
        end else if (pending_bytes.size() == 0) begin
          next_valid = 1'b0;
        end else if (pending_bytes.size() > QUIET_TAIL && hold_cycles == 0 &&
                     $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 15);
          next_valid = 1'b0;
        end else begin
          ch <= pending_bytes.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    ch_valid <= next_valid;
  end

  // Receiver: checks each token beat and stalls in random bursts.
  always @(posedge clk) begin : watch_tokens
    token_beat_t got;
    token_beat_t want;
    logic        next_stall;
    next_stall = 1'b0;
    if (!rst) begin
      got.kind = kind;
      got.data = out_byte;
      got.tk = token_kind;
      got.last = last;
      if (tok_valid && !tok_stall) begin
        if (beats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lexer check: beat with nothing due: kind=%0d byte=%h tk=%0d last=%0d",
                     got.kind, got.data, got.tk, got.last);
        end else begin
          want = beats_due.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.tk !== want.tk || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("lexer check: kind/byte/tk/last want %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                       want.kind, want.data, want.tk, want.last,
                       got.kind, got.data, got.tk, got.last);
          end
        end
      end
      // One long hold-off lets the internal queue fill and back up the input.
      if (!pressure_done && bytes_taken >= 100) begin
        hold_cycles = 300;
        pressure_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        next_stall = 1'b1;
      end else if (pending_bytes.size() <= QUIET_TAIL) begin
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        next_stall = 1'b1;
      end
    end
    tok_stall <= next_stall;
  end

  initial begin
    // Opening line: the operators <<, >, ||, &&, >> and ;, a lone ampersand, empty and escaped quotes,
    // high and control bytes, and an open quote cut off by the line end.
    opening_line = '{scl_pkg::CH_UNDER, 8'h09, scl_pkg::CH_LT, scl_pkg::CH_LT,
                     scl_pkg::CH_GT, scl_pkg::CH_BAR, scl_pkg::CH_BAR, scl_pkg::CH_AMP,
                     8'h78, scl_pkg::CH_SEMI, scl_pkg::CH_DQUOTE, scl_pkg::CH_DQUOTE,
                     8'hFF, scl_pkg::CH_SQUOTE, scl_pkg::CH_BSLASH, scl_pkg::CH_SQUOTE,
                     8'h80, scl_pkg::CH_SQUOTE, scl_pkg::CH_AMP, scl_pkg::CH_AMP,
                     scl_pkg::CH_NUL, scl_pkg::CH_SQUOTE, scl_pkg::CH_BSLASH,
                     scl_pkg::CH_NUL, 8'h01, scl_pkg::CH_GT, scl_pkg::CH_GT,
                     scl_pkg::CH_NUL};
    foreach (opening_line[i]) pending_bytes.push_back(opening_line[i]);
    while (pending_bytes.size() < N_OPENING + RANDOM_TARGET) queue_random_line();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || ch_valid) @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
